// ===== sv/dclm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dclm_pkg;

  // Default sizing handed to the top level parameters.
  localparam int LANES_DEF     = 8;
  localparam int MAX_DELAY_DEF = 4096;

  // Field widths.
  localparam int LANE_W   = 3;
  localparam int LAT_W    = 12;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int MASK_W   = 8;
  localparam int ACC_W    = 32;

  // The lane field can address no more than this many lanes.
  localparam int FIELD_LANES = 1 << LANE_W;

  // Gain scaling: unsigned Q3.13, clamped to 4.0, product rounded half up.
  localparam int GAIN_MAX   = 32768;
  localparam int FRAC_SHIFT = 13;
  localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int CONTRIB_W  = PROD_W - FRAC_SHIFT;

  // Depth of the queue between the front and back halves.
  localparam int Q_DEPTH = 4;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // One classified sample word on its way to the back half.
  typedef struct packed {
    logic                do_mem;
    logic                add;
    logic                last;
    logic                chan;
    logic [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]   gain;
    logic [MASK_W-1:0]   qmask;
    logic [LAT_W-1:0]    graph_lat;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/dclm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dclm_front
  import dclm_pkg::*;
#(
  parameter int LANES     = LANES_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  parameter int AW        = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                kind,
  input  wire logic [LANE_W-1:0]   lane,
  input  wire logic [LAT_W-1:0]    latency_frames,
  input  wire logic [SAMPLE_W-1:0] sample_value,
  input  wire logic                channel,
  input  wire logic [GAIN_W-1:0]   gain,
  input  wire logic                audible,
  input  wire logic                render_failed,
  input  wire logic                last_lane,
  output logic                     push,
  output op_t                      push_op,
  output logic [AW-1:0]            push_addr
);

  localparam int NL      = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int LW      = (NL > 1) ? $clog2(NL) : 1;
  localparam int RING    = 2 * MAX_DELAY;
  localparam int HW      = $clog2(RING);
  localparam int COMP_W  = 17;

  logic [LAT_W-1:0] lat_r   [NL];
  logic [LAT_W-1:0] lat_nxt [NL];
  logic [HW-1:0]    head_r  [NL];
  logic [HW-1:0]    head_nxt[NL];
  logic [LAT_W-1:0] max_r, max_nxt;
  logic [NL-1:0]    quar_r, quar_nxt;

  logic             in_range;
  logic [LW-1:0]    idx;
  logic [LAT_W-1:0] comp;
  logic [COMP_W-1:0] comp_sat;
  logic [HW-1:0]    len;
  logic [HW-1:0]    h_eff;
  logic [HW:0]      h_inc;
  logic             active;
  logic [MASK_W-1:0] mask_view;

  assign in_range = ({1'b0, lane} < (LANE_W + 1)'(NL));
  assign idx      = LW'(lane);

  // Classify the word, update lane state and build the queue entry.
  always_comb begin
    lat_nxt  = lat_r;
    head_nxt = head_r;
    max_nxt  = max_r;
    quar_nxt = quar_r;
    push     = 1'b0;
    comp     = '0;
    comp_sat = '0;
    len      = '0;
    h_eff    = '0;
    h_inc    = '0;
    active   = 1'b0;
    push_addr = '0;

    if (accept && (kind == KIND_REPORT)) begin
      if (in_range) begin
        lat_nxt[idx] = latency_frames;
        if (latency_frames > max_r) begin
          max_nxt = latency_frames;
        end
      end
    end else if (accept) begin
      push = 1'b1;
      if (in_range) begin
        if (render_failed) begin
          quar_nxt[idx] = 1'b1;
        end
        active = !quar_nxt[idx];
        comp   = (max_r < lat_r[idx]) ? '0 : (max_r - lat_r[idx]);
        comp_sat = COMP_W'(comp);
        if (comp_sat > COMP_W'(MAX_DELAY - 1)) begin
          comp_sat = COMP_W'(MAX_DELAY - 1);
        end
        len   = HW'({comp_sat, 1'b0});
        h_eff = (head_r[idx] >= len) ? '0 : head_r[idx];
        h_inc = {1'b0, h_eff} + 1'b1;
        push_addr = AW'(AW'(idx) * AW'(RING) + AW'(h_eff));
        if (active && (len != '0)) begin
          head_nxt[idx] = (h_inc == {1'b0, len}) ? '0 : h_inc[HW-1:0];
        end
      end
    end
  end

  // Lane quarantine bits as seen on the eight-bit mask.
  always_comb begin
    mask_view = '0;
    for (int i = 0; i < NL; i++) begin
      mask_view[i] = quar_nxt[i];
    end
  end

  always_comb begin
    push_op.do_mem    = active && (len != '0);
    push_op.add       = active && audible;
    push_op.last      = last_lane;
    push_op.chan      = channel;
    push_op.sample    = sample_value;
    push_op.gain      = (gain > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : gain;
    push_op.qmask     = mask_view;
    push_op.graph_lat = max_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= '0;
      quar_r <= '0;
      for (int i = 0; i < NL; i++) begin
        lat_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else begin
      max_r  <= max_nxt;
      quar_r <= quar_nxt;
      lat_r  <= lat_nxt;
      head_r <= head_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dclm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dclm_queue
  import dclm_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire op_t           push_op,
  input  wire logic [AW-1:0] push_addr,
  input  wire logic          pop,
  output logic               empty,
  output logic               full,
  output op_t                head_op,
  output logic [AW-1:0]      head_addr
);

  localparam int PW = $clog2(Q_DEPTH);

  op_t           op_q  [Q_DEPTH];
  logic [AW-1:0] adr_q [Q_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == (PW + 1)'(Q_DEPTH));
  assign head_op   = op_q[rd_r];
  assign head_addr = adr_q[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      op_q[wr_r]  <= push_op;
      adr_q[wr_r] <= push_addr;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dclm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dclm_back
  import dclm_pkg::*;
#(
  parameter int LANES     = LANES_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  parameter int AW        = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire op_t                 q_op,
  input  wire logic [AW-1:0]       q_addr,
  output logic                     q_pop,
  output logic                     clr_busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_mix,
  output logic                     out_chan,
  output logic                     out_ovf,
  output logic [MASK_W-1:0]        out_qmask,
  output logic [LAT_W-1:0]         out_glat
);

  localparam int NL    = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int DEPTH = NL * 2 * MAX_DELAY;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          adv;

  logic                     s1_v_r, s2_v_r;
  op_t                      s1_op_r, s2_op_r;
  logic [SAMPLE_W-1:0]      rd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [SAMPLE_W-1:0]  dly;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    biased;
  logic signed [CONTRIB_W-1:0] contrib;
  logic signed [ACC_W:0]       sum_w;
  logic signed [ACC_W-1:0]     sum;
  logic                        mix_hi, mix_lo;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_mix_r;
  logic                out_chan_r, out_ovf_r;
  logic [MASK_W-1:0]   out_qmask_r;
  logic [LAT_W-1:0]    out_glat_r;

  // The whole back pipeline moves when the output register can take a word.
  assign adv      = !out_valid_r || out_ready;
  assign q_pop    = adv && !q_empty && !clr_busy_r;
  assign clr_busy = clr_busy_r;

  // Zero the delay memory after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Delay memory: read the oldest sample and store the new one in its place.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (q_pop && q_op.do_mem) begin
      rd_r         <= mem[q_addr];
      mem[q_addr]  <= q_op.sample;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
    end
  end

  // Gain multiply on the delayed sample, both operands widened to the product width.
  always_comb begin
    dly  = s1_op_r.do_mem ? $signed(rd_r) : $signed(s1_op_r.sample);
    prod = PROD_W'(dly) * PROD_W'($signed({1'b0, s1_op_r.gain}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= q_op;
      s2_op_r <= s1_op_r;
      prod_r  <= prod;
    end
  end

  // Round to Q1.23, accumulate with 32-bit saturation, then clip the mix.
  always_comb begin
    biased  = prod_r + PROD_W'(ROUND_BIAS);
    contrib = biased[PROD_W-1:FRAC_SHIFT];
    sum_w   = {acc_r[ACC_W-1], acc_r};
    if (s2_op_r.add) begin
      sum_w = sum_w + (ACC_W + 1)'(contrib);
    end
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sum = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum = sum_w[ACC_W-1:0];
    end
    mix_hi = !sum[ACC_W-1] && (sum[ACC_W-2:SAMPLE_W-1] != '0);
    mix_lo = sum[ACC_W-1] && (sum[ACC_W-2:SAMPLE_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && s2_v_r) begin
      acc_r <= s2_op_r.last ? '0 : sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r && s2_op_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r && s2_op_r.last) begin
      if (mix_hi) begin
        out_mix_r <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (mix_lo) begin
        out_mix_r <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        out_mix_r <= sum[SAMPLE_W-1:0];
      end
      out_ovf_r   <= mix_hi || mix_lo;
      out_chan_r  <= s2_op_r.chan;
      out_qmask_r <= s2_op_r.qmask;
      out_glat_r  <= s2_op_r.graph_lat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mix   = out_mix_r;
  assign out_chan  = out_chan_r;
  assign out_ovf   = out_ovf_r;
  assign out_qmask = out_qmask_r;
  assign out_glat  = out_glat_r;

endmodule

`default_nettype wire

// ===== sv/delay_compensated_lane_mixer_core.sv =====
// Mix path: queue, s1, s2, output register. Throughput, when in_tready and out_tready
// stay high: one word a cycle, set by the single read-write port of the delay memory.
// Reset: rst_n is synchronous and active low; it clears lane latencies, heads,
// quarantine and the accumulator, then the delay memory is zeroed one entry a cycle,
// through all min(LANES, 8) * 2 * MAX_DELAY entries, with in_tready low throughout.
`timescale 1ns / 1ps
`default_nettype none

module delay_compensated_lane_mixer_core
  import dclm_pkg::*;
#(
  parameter int LANES     = LANES_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // lane, latency_frames, sample_value, channel, gain, audible, render_failed, zeros
  input  wire logic [63:0] in_tdata,
  // kind
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mix_sample, out_channel, mix_overflow, quarantine_mask, graph_latency, zeros
  output logic [47:0]      out_tdata
);

  localparam int NL = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int AW = $clog2(NL * 2 * MAX_DELAY);

  logic          accept;
  logic          push, q_empty, q_full, q_pop, clr_busy;
  op_t           push_op, q_op;
  logic [AW-1:0] push_addr, q_addr;

  logic [SAMPLE_W-1:0] out_mix;
  logic                out_chan, out_ovf;
  logic [MASK_W-1:0]   out_qmask;
  logic [LAT_W-1:0]    out_glat;

  assign in_tready = !clr_busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  dclm_front #(
    .LANES     (LANES),
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .kind           (in_tuser[0]),
    .lane           (in_tdata[2:0]),
    .latency_frames (in_tdata[14:3]),
    .sample_value   (in_tdata[38:15]),
    .channel        (in_tdata[39]),
    .gain           (in_tdata[55:40]),
    .audible        (in_tdata[56]),
    .render_failed  (in_tdata[57]),
    .last_lane      (in_tlast),
    .push           (push),
    .push_op        (push_op),
    .push_addr      (push_addr)
  );

  dclm_queue #(
    .AW (AW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .push_addr (push_addr),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .head_op   (q_op),
    .head_addr (q_addr)
  );

  dclm_back #(
    .LANES     (LANES),
    .MAX_DELAY (MAX_DELAY),
    .AW        (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_op      (q_op),
    .q_addr    (q_addr),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mix   (out_mix),
    .out_chan  (out_chan),
    .out_ovf   (out_ovf),
    .out_qmask (out_qmask),
    .out_glat  (out_glat)
  );

  // Pack the result word, padded to whole bytes.
  assign out_tdata = {2'b00, out_glat, out_qmask, out_ovf, out_chan, out_mix};

endmodule

`default_nettype wire
